// ===== hdl/v3alu_pkg.sv =====
package v3alu_pkg;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_DOT    = 3'd2,
    OP_CROSS  = 3'd3,
    OP_MAG    = 3'd4,
    OP_NORM   = 3'd5,
    OP_SETMAG = 3'd6,
    OP_RSVD   = 3'd7
  } op_t;

endpackage

// ===== hdl/vector3_arithmetic_unit.sv =====
// throughput: one request per cycle while no result waits under out_stall; the depth
//   is set by the one-bit-per-stage square root (COMP_WIDTH stages) and the three
//   divider lanes (2*COMP_WIDTH stages)
// the whole pipeline holds while a result waits under out_stall
// reset: synchronous, clears every stage valid bit; payload registers are not reset
module vector3_arithmetic_unit #(
  parameter int COMP_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   op,
  input  logic signed [COMP_WIDTH-1:0] a_x,
  input  logic signed [COMP_WIDTH-1:0] a_y,
  input  logic signed [COMP_WIDTH-1:0] a_z,
  input  logic signed [COMP_WIDTH-1:0] b_x,
  input  logic signed [COMP_WIDTH-1:0] b_y,
  input  logic signed [COMP_WIDTH-1:0] b_z,
  input  logic [COMP_WIDTH-2:0]        target_length,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COMP_WIDTH-1:0] res_x,
  output logic signed [COMP_WIDTH-1:0] res_y,
  output logic signed [COMP_WIDTH-1:0] res_z,
  output logic signed [COMP_WIDTH-1:0] res_scalar,
  output logic                         overflow,
  output logic                         zero_length
);
  import v3alu_pkg::*;

  localparam int W      = COMP_WIDTH;
  localparam int MW     = 2*W-2;
  localparam int NW     = 2*W;
  localparam int DW     = W+1;
  localparam int SQ_LAT = W;
  localparam int DV_LAT = 2*W;

  localparam logic signed [2*W+1:0] SAT_MAX = {{(W+3){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [2*W+1:0] SAT_MIN = {{(W+3){1'b1}}, {(W-1){1'b0}}};
  localparam logic signed [2*W+1:0] HALF    = {{(2*W+2-FRAC_BITS){1'b0}}, 1'b1,
                                               {(FRAC_BITS-1){1'b0}}};
  localparam logic [W-2:0]          ONE_FX  = {{(W-2-FRAC_BITS){1'b0}}, 1'b1,
                                               {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic [2:0]          op;
    logic [2:0][W-1:0]   rv;
    logic [W-1:0]        rs;
    logic                ovf;
    logic [2:0][MW-1:0]  mag;
    logic [2:0]          neg;
  } side_a_t;

  typedef struct packed {
    logic [2:0]          op;
    logic [2:0][W-1:0]   rv;
    logic [W-1:0]        rs;
    logic                ovf;
    logic [2:0]          neg;
    logic                zl;
  } side_b_t;

  // {overflow, value}
  function automatic logic [W:0] sat(input logic signed [2*W+1:0] v);
    logic [W:0] r;
    if (v > SAT_MAX) begin
      r = {1'b1, SAT_MAX[W-1:0]};
    end else if (v < SAT_MIN) begin
      r = {1'b1, SAT_MIN[W-1:0]};
    end else begin
      r = {1'b0, v[W-1:0]};
    end
    return r;
  endfunction

  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // valid chain
  logic              v1, v2, v3, v4, v5;
  logic [SQ_LAT-1:0] va;
  logic [DV_LAT-1:0] vb;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      va        <= '0;
      vb        <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      va        <= {va[SQ_LAT-2:0], v4};
      v5        <= va[SQ_LAT-1];
      vb        <= {vb[DV_LAT-2:0], v5};
      out_valid <= vb[DV_LAT-1];
    end
  end

  // stage 1: input register
  logic [2:0]          op1;
  logic signed [W-1:0] a1 [3];
  logic signed [W-1:0] b1 [3];
  logic [W-2:0]        tl1;
  logic [W-2:0]        scale1;

  always_ff @(posedge clk) begin
    if (adv) begin
      op1   <= op;
      a1[0] <= a_x;
      a1[1] <= a_y;
      a1[2] <= a_z;
      b1[0] <= b_x;
      b1[1] <= b_y;
      b1[2] <= b_z;
      tl1   <= target_length;
    end
  end

  assign scale1 = (op1 == OP_SETMAG) ? tl1 : ONE_FX;

  // stage 2: per-component lanes
  logic [2:0]            op2;
  logic signed [W:0]     sum2 [3];
  logic signed [2*W-1:0] sq2  [3];
  logic signed [2*W-1:0] dot2 [3];
  logic signed [2*W-1:0] cp2  [3];
  logic signed [2*W-1:0] cn2  [3];
  logic [MW-1:0]         mag2 [3];
  logic                  neg2 [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    v3alu_lane #(.W(W)) u_lane (
      .clk   (clk),
      .en    (adv),
      .op    (op1),
      .a     (a1[i]),
      .b     (b1[i]),
      .u0    (a1[(i+1)%3]),
      .v0    (b1[(i+2)%3]),
      .u1    (a1[(i+2)%3]),
      .v1    (b1[(i+1)%3]),
      .scale (scale1),
      .sum   (sum2[i]),
      .sq    (sq2[i]),
      .dot   (dot2[i]),
      .cp    (cp2[i]),
      .cn    (cn2[i]),
      .mag   (mag2[i]),
      .neg   (neg2[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op2 <= op1;
    end
  end

  // stage 3: merge sums across lanes
  logic [2:0]            op3;
  logic signed [2*W+1:0] dot3;
  logic signed [2*W+1:0] sqs;
  logic [2*W-1:0]        sq3;
  logic signed [2*W:0]   crs3 [3];
  logic signed [W:0]     sum3 [3];
  logic [2:0][MW-1:0]    mag3;
  logic [2:0]            neg3;

  assign sqs = (2*W+2)'(sq2[0]) + (2*W+2)'(sq2[1]) + (2*W+2)'(sq2[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      op3  <= op2;
      dot3 <= (2*W+2)'(dot2[0]) + (2*W+2)'(dot2[1]) + (2*W+2)'(dot2[2]);
      sq3  <= sqs[2*W-1:0];
      for (int i = 0; i < 3; i++) begin
        crs3[i] <= (2*W+1)'(cp2[i]) - (2*W+1)'(cn2[i]);
        sum3[i] <= sum2[i];
        mag3[i] <= mag2[i];
        neg3[i] <= neg2[i];
      end
    end
  end

  // stage 4: round and saturate the direct results
  logic signed [2*W+1:0] dot_r;
  logic [W:0]            dot_s;
  logic [W:0]            sum_s [3];
  logic [W:0]            crs_s [3];
  side_a_t               pa_next, sa4;
  logic [2*W-1:0]        sq4;

  assign dot_r = (dot3 + HALF) >>> FRAC_BITS;
  assign dot_s = sat(dot_r);

  for (genvar i = 0; i < 3; i++) begin : g_sat4
    logic signed [2*W+1:0] crs_r;
    assign crs_r    = ((2*W+2)'(crs3[i]) + HALF) >>> FRAC_BITS;
    assign crs_s[i] = sat(crs_r);
    assign sum_s[i] = sat((2*W+2)'(sum3[i]));
  end

  always_comb begin
    pa_next     = '0;
    pa_next.op  = op3;
    pa_next.mag = mag3;
    pa_next.neg = neg3;
    case (op3) inside
      OP_ADD, OP_SUB: begin
        for (int i = 0; i < 3; i++) begin
          pa_next.rv[i] = sum_s[i][W-1:0];
        end
        pa_next.ovf = sum_s[0][W] | sum_s[1][W] | sum_s[2][W];
      end
      OP_DOT: begin
        pa_next.rs  = dot_s[W-1:0];
        pa_next.ovf = dot_s[W];
      end
      OP_CROSS: begin
        for (int i = 0; i < 3; i++) begin
          pa_next.rv[i] = crs_s[i][W-1:0];
        end
        pa_next.ovf = crs_s[0][W] | crs_s[1][W] | crs_s[2][W];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa4 <= pa_next;
      sq4 <= sq3;
    end
  end

  // square root with the side data riding alongside
  logic [W-1:0] root;
  side_a_t      sa_dly [SQ_LAT];

  v3alu_sqrt #(.W(W)) u_sqrt (
    .clk  (clk),
    .en   (adv),
    .rad  (sq4),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_dly[0] <= sa4;
      for (int k = 1; k < SQ_LAT; k++) begin
        sa_dly[k] <= sa_dly[k-1];
      end
    end
  end

  // stage 5: magnitude result, zero check, divider operands
  side_a_t       sa_end;
  side_b_t       pb_next, sb5;
  logic [NW-1:0] num5 [3];
  logic [DW-1:0] den5;

  assign sa_end = sa_dly[SQ_LAT-1];

  always_comb begin
    pb_next     = '0;
    pb_next.op  = sa_end.op;
    pb_next.rv  = sa_end.rv;
    pb_next.rs  = sa_end.rs;
    pb_next.ovf = sa_end.ovf;
    pb_next.neg = sa_end.neg;
    case (sa_end.op) inside
      OP_MAG: begin
        pb_next.rs  = root[W-1] ? SAT_MAX[W-1:0] : root;
        pb_next.ovf = root[W-1];
      end
      OP_NORM, OP_SETMAG: begin
        pb_next.zl = (root == '0);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb5  <= pb_next;
      den5 <= {root, 1'b0};
      for (int i = 0; i < 3; i++) begin
        // 2*|a*scale| + m over 2*m rounds half away from zero
        num5[i] <= NW'({sa_end.mag[i], 1'b0}) + NW'(root);
      end
    end
  end

  // divider lanes
  logic [NW-1:0] quot [3];
  side_b_t       sb_dly [DV_LAT];

  for (genvar i = 0; i < 3; i++) begin : g_div
    v3alu_div #(.NW(NW), .DW(DW)) u_div (
      .clk  (clk),
      .en   (adv),
      .num  (num5[i]),
      .den  (den5),
      .quot (quot[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_dly[0] <= sb5;
      for (int k = 1; k < DV_LAT; k++) begin
        sb_dly[k] <= sb_dly[k-1];
      end
    end
  end

  // stage 6: final select into the output register
  side_b_t    sb_end;
  logic [W:0] q_s [3];

  assign sb_end = sb_dly[DV_LAT-1];

  for (genvar i = 0; i < 3; i++) begin : g_sat6
    logic signed [2*W+1:0] qe;
    assign qe     = {2'b00, quot[i]};
    assign q_s[i] = sat(sb_end.neg[i] ? -qe : qe);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_x       <= sb_end.rv[0];
      res_y       <= sb_end.rv[1];
      res_z       <= sb_end.rv[2];
      res_scalar  <= sb_end.rs;
      overflow    <= sb_end.ovf;
      zero_length <= sb_end.zl;
      if ((sb_end.op == OP_NORM || sb_end.op == OP_SETMAG) && !sb_end.zl) begin
        res_x    <= q_s[0][W-1:0];
        res_y    <= q_s[1][W-1:0];
        res_z    <= q_s[2][W-1:0];
        overflow <= q_s[0][W] | q_s[1][W] | q_s[2][W];
      end
    end
  end

  a_stall_backpressure: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output backpressure");

  a_zero_length_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_length |->
      res_x == '0 && res_y == '0 && res_z == '0 && res_scalar == '0 && !overflow)
    else $error("zero length result carries nonzero data");

  a_scalar_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_scalar != '0 |-> res_x == '0 && res_y == '0 && res_z == '0)
    else $error("scalar result with nonzero vector");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

// ===== hdl/v3alu_lane.sv =====
module v3alu_lane #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2:0]            op,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  input  logic signed [W-1:0]   u0,
  input  logic signed [W-1:0]   v0,
  input  logic signed [W-1:0]   u1,
  input  logic signed [W-1:0]   v1,
  input  logic [W-2:0]          scale,
  output logic signed [W:0]     sum,
  output logic signed [2*W-1:0] sq,
  output logic signed [2*W-1:0] dot,
  output logic signed [2*W-1:0] cp,
  output logic signed [2*W-1:0] cn,
  output logic [2*W-3:0]        mag,
  output logic                  neg
);
  import v3alu_pkg::*;

  logic signed [W:0]  ae, be;
  logic [W-1:0]       a_abs;
  logic [2*W-2:0]     mag_full;

  assign ae       = (W+1)'(a);
  assign be       = (W+1)'(b);
  assign a_abs    = a[W-1] ? (~a + 1'b1) : a;
  assign mag_full = a_abs * scale;

  always_ff @(posedge clk) begin
    if (en) begin
      sum <= (op == OP_SUB) ? ae - be : ae + be;
      sq  <= a * a;
      dot <= a * b;
      cp  <= u0 * v0;
      cn  <= u1 * v1;
      // |a| * scale stays below 2^(2W-2)
      mag <= mag_full[2*W-3:0];
      neg <= a[W-1];
    end
  end

endmodule

// ===== hdl/v3alu_sqrt.sv =====
module v3alu_sqrt #(
  parameter int W = 32
) (
  input  logic           clk,
  input  logic           en,
  input  logic [2*W-1:0] rad,
  output logic [W-1:0]   root
);

  logic [2*W-1:0] s_q    [W-1];
  logic [W:0]     rem_q  [W-1];
  logic [W-1:0]   root_q [W];

  // one root bit per stage, two radicand bits consumed per stage
  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [2*W-1:0] s_in;
    logic [W:0]     rem_in;
    logic [W-1:0]   root_in;
    logic [W+1:0]   rem_sh, trial, diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign s_in    = rad;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign s_in    = s_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign rem_sh = {rem_in[W-1:0], s_in[2*W-1 -: 2]};
    assign trial  = {1'b0, root_in[W-2:0], 2'b01};
    assign ge     = (rem_sh >= trial);
    assign diff   = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[k] <= {root_in[W-2:0], ge};
      end
    end

    if (k < W-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          s_q[k]   <= {s_in[2*W-3:0], 2'b00};
          rem_q[k] <= ge ? diff[W:0] : rem_sh[W:0];
        end
      end
    end
  end

  assign root = root_q[W-1];

endmodule

// ===== hdl/v3alu_div.sv =====
module v3alu_div #(
  parameter int NW = 64,
  parameter int DW = 33
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quot
);

  // numerator shifts out at the top while quotient bits shift in below
  logic [NW-1:0] nq_q  [NW];
  logic [DW-1:0] rem_q [NW-1];
  logic [DW-1:0] den_q [NW-1];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [NW-1:0] nq_in;
    logic [DW-1:0] rem_in, den_in;
    logic [DW:0]   rs, diff;
    logic          ge;

    if (k == 0) begin : g_first
      assign nq_in  = num;
      assign rem_in = '0;
      assign den_in = den;
    end else begin : g_next
      assign nq_in  = nq_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
    end

    assign rs   = {rem_in, nq_in[NW-1]};
    assign ge   = (rs >= {1'b0, den_in});
    assign diff = rs - {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        nq_q[k] <= {nq_in[NW-2:0], ge};
      end
    end

    if (k < NW-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_q[k] <= ge ? diff[DW-1:0] : rs[DW-1:0];
          den_q[k] <= den_in;
        end
      end
    end
  end

  assign quot = nq_q[NW-1];

endmodule
